// File: src/awm_pkg.sv
`default_nettype none

package awm_pkg;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned CH_W   = 5;

  localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TEXT    = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd3;

  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_LOAD,
    OP_TEXT,
    OP_RESTART,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [CH_W-1:0] letter;
  } item_t;

  typedef struct packed {
    logic avail;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

// File: src/awm_ram.sv
`default_nettype none

module awm_ram #(
  parameter int unsigned WIDTH = 5,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic                                     re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read and a write to the same address in one cycle return the old content.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: src/awm_front.sv
`default_nettype none

module awm_front #(
  parameter int unsigned ALPHABET = 26
) (
  input  wire logic                        in_valid_i,
  input  wire logic [awm_pkg::FUNC_W-1:0]  func_i,
  input  wire logic [awm_pkg::CH_W-1:0]    ch_i,
  input  wire awm_pkg::q_stat_t            q_stat_i,
  output logic                             in_stall_o,
  output logic                             push_o,
  output awm_pkg::item_t                   item_o
);

  logic letter_ok;

  assign letter_ok  = (32'(ch_i) < ALPHABET);
  assign in_stall_o = q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

  always_comb begin
    item_o.letter = ch_i;
    unique case (func_i)
      awm_pkg::FUNC_CLEAR:   item_o.op = awm_pkg::OP_CLEAR;
      awm_pkg::FUNC_LOAD:    item_o.op = letter_ok ? awm_pkg::OP_LOAD : awm_pkg::OP_NOP;
      awm_pkg::FUNC_TEXT:    item_o.op = letter_ok ? awm_pkg::OP_TEXT : awm_pkg::OP_NOP;
      awm_pkg::FUNC_RESTART: item_o.op = awm_pkg::OP_RESTART;
      default:               item_o.op = awm_pkg::OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

// File: src/awm_queue.sv
`default_nettype none

module awm_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire awm_pkg::item_t push_item_i,
  input  wire logic           pop_i,
  output awm_pkg::item_t      head_o,
  output awm_pkg::q_stat_t    stat_o
);

  awm_pkg::item_t entry_q [2];
  logic           wptr_q, wptr_d;
  logic           rptr_q, rptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           do_pop;

  assign do_pop = pop_i && (cnt_q != 2'd0);

  always_comb begin
    wptr_d = wptr_q ^ push_i;
    rptr_d = rptr_q ^ do_pop;
    cnt_d  = cnt_q + {1'b0, push_i} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= push_item_i;
    end
  end

  assign head_o       = entry_q[rptr_q];
  assign stat_o.avail = (cnt_q != 2'd0);
  assign stat_o.full  = (cnt_q == 2'd2);

endmodule

`default_nettype wire

// File: src/awm_back.sv
`default_nettype none

module awm_back #(
  parameter int unsigned MAX_PAT  = 64,
  parameter int unsigned ALPHABET = 26
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire awm_pkg::item_t   head_i,
  input  wire awm_pkg::q_stat_t q_stat_i,
  output logic                  pop_o,
  input  wire logic             out_stall_i,
  output logic                  out_valid_o,
  output logic                  window_match_o,
  output logic                  found_o,
  output logic                  pattern_overflow_o
);

  localparam int unsigned LEN_W = $clog2(MAX_PAT + 1);
  localparam int unsigned POS_W = (MAX_PAT > 1) ? $clog2(MAX_PAT) : 1;
  localparam int unsigned CH_W  = awm_pkg::CH_W;

  typedef struct packed {
    awm_pkg::op_e    op;
    logic [CH_W-1:0] letter;
    logic            drop;
    logic            dec;
    logic            full;
  } stage_t;

  logic             adv;
  logic             pop;
  logic [LEN_W-1:0] plen_q, plen_d;
  logic [LEN_W-1:0] tseen_q, tseen_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             ram_we;
  logic [CH_W-1:0]  old_letter;
  stage_t           a_stage;
  stage_t           b_q;
  logic             b_valid_q;

  logic [LEN_W-1:0] pcnt_q [ALPHABET];
  logic [LEN_W-1:0] wcnt_q [ALPHABET];
  logic [LEN_W-1:0] pcnt_inc [ALPHABET];
  logic [LEN_W-1:0] wcnt_nxt [ALPHABET];
  logic             all_eq;
  logic             found_q, ovf_q;
  logic             res_match, res_found, res_ovf;
  logic             out_valid_q, match_q, found_out_q, ovf_out_q;

  assign adv   = !out_valid_q || !out_stall_i;
  assign pop   = adv && q_stat_i.avail;
  assign pop_o = pop;

  always_comb begin
    logic full_before;
    full_before    = (tseen_q >= plen_q);
    plen_d         = plen_q;
    tseen_d        = tseen_q;
    pos_d          = pos_q;
    ram_we         = 1'b0;
    a_stage.op     = head_i.op;
    a_stage.letter = head_i.letter;
    a_stage.drop   = 1'b0;
    a_stage.dec    = 1'b0;
    a_stage.full   = 1'b0;
    unique case (head_i.op)
      awm_pkg::OP_CLEAR: begin
        plen_d  = '0;
        tseen_d = '0;
        pos_d   = '0;
      end
      awm_pkg::OP_RESTART: begin
        tseen_d = '0;
        pos_d   = '0;
      end
      awm_pkg::OP_LOAD: begin
        if (32'(plen_q) >= MAX_PAT) begin
          a_stage.drop = 1'b1;
        end else begin
          plen_d  = plen_q + LEN_W'(1);
          tseen_d = '0;
          pos_d   = '0;
        end
      end
      awm_pkg::OP_TEXT: begin
        if (plen_q == '0) begin
          a_stage.op = awm_pkg::OP_NOP;
        end else begin
          ram_we      = 1'b1;
          a_stage.dec = full_before;
          if (!full_before) begin
            tseen_d = tseen_q + LEN_W'(1);
          end
          a_stage.full = full_before || ((tseen_q + LEN_W'(1)) == plen_q);
          if ((LEN_W'(pos_q) + LEN_W'(1)) == plen_q) begin
            pos_d = '0;
          end else begin
            pos_d = pos_q + POS_W'(1);
          end
        end
      end
      default: begin
        a_stage.op = awm_pkg::OP_NOP;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q  <= '0;
      tseen_q <= '0;
      pos_q   <= '0;
    end else if (pop) begin
      plen_q  <= plen_d;
      tseen_q <= tseen_d;
      pos_q   <= pos_d;
    end
  end

  awm_ram #(
    .WIDTH(CH_W),
    .DEPTH(MAX_PAT)
  ) u_line (
    .clk_i  (clk_i),
    .we_i   (pop && ram_we),
    .waddr_i(pos_q),
    .wdata_i(head_i.letter),
    .re_i   (pop),
    .raddr_i(pos_q),
    .rdata_o(old_letter)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (adv) begin
      b_valid_q <= pop;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      b_q <= a_stage;
    end
  end

  always_comb begin
    logic inc_hit;
    logic dec_hit;
    all_eq = 1'b1;
    for (int k = 0; k < ALPHABET; k++) begin
      inc_hit     = (32'(b_q.letter) == k);
      dec_hit     = b_q.dec && (32'(old_letter) == k) && (wcnt_q[k] != '0);
      pcnt_inc[k] = pcnt_q[k] + LEN_W'(inc_hit);
      wcnt_nxt[k] = wcnt_q[k] + LEN_W'(inc_hit) - LEN_W'(dec_hit);
      if (wcnt_nxt[k] != pcnt_q[k]) begin
        all_eq = 1'b0;
      end
    end
  end

  always_comb begin
    res_match = 1'b0;
    res_found = found_q;
    res_ovf   = ovf_q;
    unique case (b_q.op)
      awm_pkg::OP_CLEAR: begin
        res_found = 1'b0;
        res_ovf   = 1'b0;
      end
      awm_pkg::OP_RESTART: begin
        res_found = 1'b0;
      end
      awm_pkg::OP_LOAD: begin
        if (b_q.drop) begin
          res_ovf = 1'b1;
        end else begin
          res_found = 1'b0;
        end
      end
      awm_pkg::OP_TEXT: begin
        res_match = b_q.full && all_eq;
        res_found = found_q || res_match;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      ovf_q   <= 1'b0;
      for (int k = 0; k < ALPHABET; k++) begin
        pcnt_q[k] <= '0;
        wcnt_q[k] <= '0;
      end
    end else if (adv && b_valid_q) begin
      found_q <= res_found;
      ovf_q   <= res_ovf;
      for (int k = 0; k < ALPHABET; k++) begin
        case (b_q.op)
          awm_pkg::OP_CLEAR: begin
            pcnt_q[k] <= '0;
            wcnt_q[k] <= '0;
          end
          awm_pkg::OP_RESTART: begin
            wcnt_q[k] <= '0;
          end
          awm_pkg::OP_LOAD: begin
            if (!b_q.drop) begin
              pcnt_q[k] <= pcnt_inc[k];
              wcnt_q[k] <= '0;
            end
          end
          awm_pkg::OP_TEXT: begin
            wcnt_q[k] <= wcnt_nxt[k];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && b_valid_q) begin
      match_q     <= res_match;
      found_out_q <= res_found;
      ovf_out_q   <= res_ovf;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign window_match_o     = match_q;
  assign found_o            = found_out_q;
  assign pattern_overflow_o = ovf_out_q;

endmodule

`default_nettype wire

// File: src/anagram_window_matcher.sv
// Sliding-window anagram search. Send a clear beat, then the pattern one letter per load beat,
// then text letters; every beat returns one result, and a text beat reports whether the last
// pattern-length text letters are a permutation of the pattern, with sticky found and pattern
// overflow flags. The block sustains one beat per clock cycle while the output is not stalled;
// a taken beat is registered in the back end's b stage (b_q) and then in its output registers.
// The back end updates the window histogram by one increment and, once the window is full, one
// decrement, and compares it against the pattern histogram, with the outgoing letter read from
// the delay-line memory on a registered read-before-write port. A two-entry queue between the
// classifier and the back end holds beats while the output is stalled.
`default_nettype none

module anagram_window_matcher #(
  parameter int unsigned MAX_PAT  = 64,
  parameter int unsigned ALPHABET = 26
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [awm_pkg::FUNC_W-1:0] func_i,
  input  wire logic [awm_pkg::CH_W-1:0]   ch_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic                            window_match_o,
  output logic                            found_o,
  output logic                            pattern_overflow_o
);

  awm_pkg::q_stat_t q_stat;
  awm_pkg::item_t   push_item;
  awm_pkg::item_t   head_item;
  logic             push;
  logic             pop;

  awm_front #(
    .ALPHABET(ALPHABET)
  ) u_front (
    .in_valid_i(in_valid_i),
    .func_i    (func_i),
    .ch_i      (ch_i),
    .q_stat_i  (q_stat),
    .in_stall_o(in_stall_o),
    .push_o    (push),
    .item_o    (push_item)
  );

  awm_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_item_i(push_item),
    .pop_i      (pop),
    .head_o     (head_item),
    .stat_o     (q_stat)
  );

  awm_back #(
    .MAX_PAT (MAX_PAT),
    .ALPHABET(ALPHABET)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .head_i            (head_item),
    .q_stat_i          (q_stat),
    .pop_o             (pop),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .window_match_o    (window_match_o),
    .found_o           (found_o),
    .pattern_overflow_o(pattern_overflow_o)
  );

endmodule

`default_nettype wire

// File: src/awm_checker.sv
`default_nettype none

module awm_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic window_match_o,
  input wire logic found_o,
  input wire logic pattern_overflow_o
);

  logic       in_beat;
  logic       out_beat;
  logic [2:0] pending_q;
  logic       last_found_q;

  assign in_beat  = in_valid_i && !in_stall_o;
  assign out_beat = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q    <= 3'd0;
      last_found_q <= 1'b0;
    end else begin
      pending_q <= pending_q + {2'b0, in_beat} - {2'b0, out_beat};
      if (out_beat) begin
        last_found_q <= found_o;
      end
    end
  end

  a_match_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && window_match_o |-> found_o)
    else $error("window match shown without found");

  a_found_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && found_o && !window_match_o |-> last_found_q)
    else $error("found rose without a window match");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat |-> pending_q != 3'd0)
    else $error("result beat without an accepted input beat");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd4)
    else $error("more beats in flight than the block can hold");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(window_match_o)
      && $stable(found_o) && $stable(pattern_overflow_o))
    else $error("stalled result beat changed");

endmodule

bind anagram_window_matcher awm_checker u_awm_checker (.*);

`default_nettype wire
